/* design/bwm_pkg.sv */
`timescale 1ns / 1ps
// Package for the bandwidth meter: widths, codes, handshake structs between
// the top level and the tick engine. No dependencies.
package bwm_pkg;

  localparam int RATE_BITS   = 40;
  localparam int PERIOD_W    = 20;
  localparam int LEN_W       = 16;
  localparam int ELAPSED_W   = 24;
  localparam int TOTAL_W     = 48;
  localparam int USEC_W      = 20;
  localparam int TWO_T_W     = PERIOD_W + 1;
  localparam int DIV_W       = ELAPSED_W + 1;
  localparam int MPLIER_W    = ELAPSED_W;
  localparam int RAW_PROD_W  = TOTAL_W + USEC_W;
  localparam int NUM_W       = RATE_BITS + ELAPSED_W + 2;
  localparam int ACC_W       = (RAW_PROD_W > NUM_W) ? RAW_PROD_W : NUM_W;
  localparam int MCAND_W     = (TOTAL_W > RATE_BITS + 1) ? TOTAL_W : RATE_BITS + 1;
  localparam int CNT_W       = $clog2(ACC_W);

  localparam logic [PERIOD_W-1:0]  PERIOD_RESET = PERIOD_W'(100000);
  localparam logic [MPLIER_W-1:0]  USEC_PER_SEC = MPLIER_W'(1000000);
  localparam logic [RATE_BITS-1:0] RATE_MAX     = {RATE_BITS{1'b1}};
  localparam logic [TOTAL_W-1:0]   TOTAL_MAX    = {TOTAL_W{1'b1}};

  localparam logic CMD_PACKET = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef struct packed {
    logic                  start;
    logic [ELAPSED_W-1:0]  elapsed;
    logic [TOTAL_W-1:0]    byte_total;
    logic [RATE_BITS-1:0]  smoothed;
    logic [RATE_BITS-1:0]  last_raw;
    logic [PERIOD_W-1:0]   period;
  } bwm_start_t;

  typedef struct packed {
    logic                  done;
    logic                  zero;
    logic [RATE_BITS-1:0]  filt;
    logic [RATE_BITS-1:0]  raw;
  } bwm_result_t;

  function automatic logic [RATE_BITS-1:0] bwm_sat(input logic [ACC_W-1:0] v);
    logic [RATE_BITS-1:0] r;
    if (|v[ACC_W-1:RATE_BITS]) begin
      r = RATE_MAX;
    end else begin
      r = v[RATE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

/* design/bwm_in_if.sv */
`timescale 1ns / 1ps
// Input channel of the bandwidth meter: valid/ready plus packet or tick fields.
// Depends on bwm_pkg.
interface bwm_in_if;
  import bwm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic [LEN_W-1:0]     packet_length;
  logic [ELAPSED_W-1:0] elapsed_us;

  modport source (output valid, cmd, packet_length, elapsed_us, input ready);
  modport sink   (input valid, cmd, packet_length, elapsed_us, output ready);
endinterface

/* design/bwm_out_if.sv */
`timescale 1ns / 1ps
// Result channel of the bandwidth meter: valid/ready plus the rate fields.
// Depends on bwm_pkg.
interface bwm_out_if;
  import bwm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [RATE_BITS-1:0] filtered_rate;
  logic [RATE_BITS-1:0] raw_rate;
  logic                 zero_interval;

  modport source (output valid, filtered_rate, raw_rate, zero_interval, input ready);
  modport sink   (input valid, filtered_rate, raw_rate, zero_interval, output ready);
endinterface

/* design/bandwidth_meter_lowpass.sv */
`timescale 1ns / 1ps
// Bandwidth meter with bilinear first-order low-pass smoothing.
//
// in_if  : packet (cmd 0, packet_length bytes) or tick (cmd 1, elapsed_us).
// out_if : one item per tick: filtered_rate, raw_rate, zero_interval.
// cfg_we / cfg_data : filter period in microseconds, written when idle.
//
// A packet item adds to a saturating 48-bit byte count; back-to-back packets
// run at one item per cycle while in_if.ready is high, and give no result.
// A tick with non-zero elapsed time is worked by the tick engine on one shared
// 68-bit adder: three 24-step shift-add multiplies, two 68-step restoring
// divides and one combine step. A zero-interval tick skips the arithmetic and
// goes from the idle state straight to the done state with its flagged result.
// in_if.ready is low from tick acceptance until its result is loaded into the
// output register; packets are taken while an earlier result waits there.
// If the receiver stalls, the finished tick holds in the engine until the
// output register frees. Reset sets the period to 100000 us and clears the
// byte count, the smoothed rate and the previous raw rate.
// Depends on bwm_pkg, bwm_in_if, bwm_out_if, bwm_engine.
module bandwidth_meter_lowpass (
  input  logic                           clk,
  input  logic                           rst_n,
  bwm_in_if.sink                         in_if,
  bwm_out_if.source                      out_if,
  input  logic                           cfg_we,
  input  logic [bwm_pkg::PERIOD_W-1:0]   cfg_data
);
  import bwm_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [PERIOD_W-1:0]  period_r;
  logic [TOTAL_W-1:0]   byte_total_r, byte_total_nxt;
  logic [RATE_BITS-1:0] smoothed_r, smoothed_nxt;
  logic [RATE_BITS-1:0] last_raw_r, last_raw_nxt;
  logic [RATE_BITS-1:0] out_filt_r, out_raw_r;
  logic                 out_zero_r;

  logic                 accept, pkt, tick, ack;
  logic [TOTAL_W:0]     total_sum;
  bwm_start_t           req;
  bwm_result_t          res;

  assign in_if.ready = ~busy_r;
  assign accept      = in_if.valid & ~busy_r;
  assign pkt         = accept & (in_if.cmd == CMD_PACKET);
  assign tick        = accept & (in_if.cmd == CMD_TICK);
  assign ack         = res.done & (~out_valid_r | out_if.ready);
  assign total_sum   = {1'b0, byte_total_r} + (TOTAL_W + 1)'(in_if.packet_length);

  assign req.start      = tick;
  assign req.elapsed    = in_if.elapsed_us;
  assign req.byte_total = byte_total_r;
  assign req.smoothed   = smoothed_r;
  assign req.last_raw   = last_raw_r;
  assign req.period     = period_r;

  bwm_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .ack   (ack),
    .res   (res)
  );

  always_comb begin
    busy_nxt       = busy_r;
    out_valid_nxt  = out_valid_r;
    byte_total_nxt = byte_total_r;
    smoothed_nxt   = smoothed_r;
    last_raw_nxt   = last_raw_r;
    if (pkt) begin
      byte_total_nxt = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
    end
    if (tick) begin
      busy_nxt = 1'b1;
    end
    if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (ack) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      // a zero-interval tick leaves the filter state alone
      if (!res.zero) begin
        smoothed_nxt   = res.filt;
        last_raw_nxt   = res.raw;
        byte_total_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      period_r     <= PERIOD_RESET;
      byte_total_r <= '0;
      smoothed_r   <= '0;
      last_raw_r   <= '0;
    end else begin
      busy_r       <= busy_nxt;
      out_valid_r  <= out_valid_nxt;
      byte_total_r <= byte_total_nxt;
      smoothed_r   <= smoothed_nxt;
      last_raw_r   <= last_raw_nxt;
      if (cfg_we) begin
        period_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ack) begin
      out_filt_r <= res.filt;
      out_raw_r  <= res.raw;
      out_zero_r <= res.zero;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.filtered_rate = out_filt_r;
  assign out_if.raw_rate      = out_raw_r;
  assign out_if.zero_interval = out_zero_r;
endmodule

/* design/bwm_addsub.sv */
`timescale 1ns / 1ps
// Shared wide adder/subtractor used for every multiply, divide and combine step.
// Depends on bwm_pkg.
module bwm_addsub (
  input  logic [bwm_pkg::ACC_W-1:0] x,
  input  logic [bwm_pkg::ACC_W-1:0] y,
  input  logic                      sub,
  output logic [bwm_pkg::ACC_W-1:0] sum,
  output logic                      carry
);
  import bwm_pkg::*;

  logic [ACC_W:0] full;

  // carry = 1 on subtract means x >= y
  assign full  = {1'b0, x} + {1'b0, (sub ? ~y : y)} + {{ACC_W{1'b0}}, sub};
  assign sum   = full[ACC_W-1:0];
  assign carry = full[ACC_W];
endmodule

/* design/bwm_engine.sv */
`timescale 1ns / 1ps
// Tick engine: shift-add multiplies and restoring divides on one shared adder,
// stepped by a small sequencer. Depends on bwm_pkg and bwm_addsub.
module bwm_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bwm_pkg::bwm_start_t  req,
  input  logic                 ack,
  output bwm_pkg::bwm_result_t res
);
  import bwm_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_MUL_RAW  = 8'b0000_0010,
    S_DIV_RAW  = 8'b0000_0100,
    S_MUL_NEG  = 8'b0000_1000,
    S_MUL_POS  = 8'b0001_0000,
    S_COMBINE  = 8'b0010_0000,
    S_DIV_FILT = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } eng_state_t;

  eng_state_t state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic [ACC_W-1:0]     hold_r, hold_nxt;
  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [MCAND_W-1:0]   mcand_r, mcand_nxt;
  logic [MPLIER_W-1:0]  mplier_r, mplier_nxt;
  logic [ELAPSED_W-1:0] d_r, d_nxt;
  logic [TWO_T_W-1:0]   two_t_r, two_t_nxt;
  logic [RATE_BITS-1:0] bprev_r, bprev_nxt;
  logic [RATE_BITS-1:0] rprev_r, rprev_nxt;
  logic [RATE_BITS-1:0] raw_r, raw_nxt;
  logic [RATE_BITS-1:0] filt_r, filt_nxt;
  logic                 zero_r, zero_nxt;
  logic                 neg_r, neg_nxt;

  logic [ACC_W-1:0]     alu_x, alu_y, alu_sum;
  logic                 alu_sub, alu_carry;
  logic [DIV_W:0]       shifted;
  logic [DIV_W-1:0]     divisor;
  logic [DIV_W-1:0]     sum_td;
  logic                 t_below_d;
  logic [DIV_W-1:0]     diff_td;
  logic [ACC_W-1:0]     quo;
  logic                 mul_last, div_last;

  bwm_addsub u_addsub (
    .x     (alu_x),
    .y     (alu_y),
    .sub   (alu_sub),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  assign sum_td    = DIV_W'(two_t_r) + DIV_W'(d_r);
  assign t_below_d = DIV_W'(two_t_r) < DIV_W'(d_r);
  assign diff_td   = t_below_d ? (DIV_W'(d_r) - DIV_W'(two_t_r))
                               : (DIV_W'(two_t_r) - DIV_W'(d_r));
  assign shifted   = {rem_r, acc_r[ACC_W-1]};
  assign divisor   = (state_r == S_DIV_RAW) ? DIV_W'(d_r) : sum_td;
  assign quo       = {acc_r[ACC_W-2:0], alu_carry};
  assign mul_last  = (cnt_r == CNT_W'(MPLIER_W - 1));
  assign div_last  = (cnt_r == CNT_W'(ACC_W - 1));

  // adder operand selection
  always_comb begin
    alu_x   = '0;
    alu_y   = '0;
    alu_sub = 1'b0;
    case (state_r)
      S_MUL_RAW, S_MUL_NEG, S_MUL_POS: begin
        alu_x = {acc_r[ACC_W-2:0], 1'b0};
        alu_y = mplier_r[MPLIER_W-1] ? ACC_W'(mcand_r) : '0;
      end
      S_DIV_RAW, S_DIV_FILT: begin
        alu_x   = ACC_W'(shifted);
        alu_y   = ACC_W'(divisor);
        alu_sub = 1'b1;
      end
      S_COMBINE: begin
        alu_x   = acc_r;
        alu_y   = hold_r;
        alu_sub = t_below_d;
      end
      default: begin
        alu_x = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    hold_nxt   = hold_r;
    rem_nxt    = rem_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    d_nxt      = d_r;
    two_t_nxt  = two_t_r;
    bprev_nxt  = bprev_r;
    rprev_nxt  = rprev_r;
    raw_nxt    = raw_r;
    filt_nxt   = filt_r;
    zero_nxt   = zero_r;
    neg_nxt    = neg_r;
    case (state_r)
      S_IDLE: begin
        if (req.start) begin
          d_nxt      = req.elapsed;
          two_t_nxt  = {req.period, 1'b0};
          bprev_nxt  = req.smoothed;
          rprev_nxt  = req.last_raw;
          acc_nxt    = '0;
          cnt_nxt    = '0;
          mcand_nxt  = MCAND_W'(req.byte_total);
          mplier_nxt = USEC_PER_SEC;
          if (req.elapsed == '0) begin
            zero_nxt  = 1'b1;
            raw_nxt   = '0;
            filt_nxt  = '0;
            state_nxt = S_DONE;
          end else begin
            zero_nxt  = 1'b0;
            state_nxt = S_MUL_RAW;
          end
        end
      end
      S_MUL_RAW, S_MUL_NEG, S_MUL_POS: begin
        acc_nxt    = alu_sum;
        mplier_nxt = {mplier_r[MPLIER_W-2:0], 1'b0};
        cnt_nxt    = cnt_r + 1'b1;
        if (mul_last) begin
          cnt_nxt = '0;
          if (state_r == S_MUL_RAW) begin
            rem_nxt   = '0;
            state_nxt = S_DIV_RAW;
          end else if (state_r == S_MUL_NEG) begin
            // park Bprev*|2T-d| and start d*(R+Rprev)
            hold_nxt   = alu_sum;
            acc_nxt    = '0;
            mcand_nxt  = MCAND_W'({1'b0, raw_r} + {1'b0, rprev_r});
            mplier_nxt = d_r;
            state_nxt  = S_MUL_POS;
          end else begin
            state_nxt = S_COMBINE;
          end
        end
      end
      S_DIV_RAW, S_DIV_FILT: begin
        rem_nxt = alu_carry ? alu_sum[DIV_W-1:0] : shifted[DIV_W-1:0];
        acc_nxt = quo;
        cnt_nxt = cnt_r + 1'b1;
        if (div_last) begin
          cnt_nxt = '0;
          if (state_r == S_DIV_RAW) begin
            raw_nxt    = bwm_sat(quo);
            acc_nxt    = '0;
            mcand_nxt  = MCAND_W'(bprev_r);
            mplier_nxt = MPLIER_W'(diff_td);
            state_nxt  = S_MUL_NEG;
          end else begin
            filt_nxt  = neg_r ? '0 : bwm_sat(quo);
            state_nxt = S_DONE;
          end
        end
      end
      S_COMBINE: begin
        acc_nxt   = alu_sum;
        neg_nxt   = t_below_d & ~alu_carry;
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIV_FILT;
      end
      S_DONE: begin
        if (ack) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    hold_r   <= hold_nxt;
    rem_r    <= rem_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    d_r      <= d_nxt;
    two_t_r  <= two_t_nxt;
    bprev_r  <= bprev_nxt;
    rprev_r  <= rprev_nxt;
    raw_r    <= raw_nxt;
    filt_r   <= filt_nxt;
    zero_r   <= zero_nxt;
    neg_r    <= neg_nxt;
  end

  assign res.done = (state_r == S_DONE);
  assign res.zero = zero_r;
  assign res.filt = filt_r;
  assign res.raw  = raw_r;
endmodule

/* design/bwm_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the bandwidth meter, bound to the top level.
// Depends on bwm_pkg and bandwidth_meter_lowpass.
module bwm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_cmd,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bwm_pkg::RATE_BITS-1:0] out_filt,
  input logic [bwm_pkg::RATE_BITS-1:0] out_raw,
  input logic                          out_zero
);
  import bwm_pkg::*;

  // stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_filt) && $stable(out_raw)
      && $stable(out_zero))
  else $error("stalled result changed");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero |-> out_filt == '0 && out_raw == '0)
  else $error("zero-interval item carries a rate");

  // a taken tick blocks the input: in_ready drops once the tick is accepted
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == CMD_TICK |=> !in_ready)
  else $error("input taken during tick");

  // packets never produce a result
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == CMD_PACKET && !out_valid |=> !out_valid)
  else $error("result after packet item");

  assert property (@(posedge clk) !rst_n |=> !out_valid)
  else $error("result valid after reset");
endmodule

bind bandwidth_meter_lowpass bwm_checker u_bwm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .in_cmd    (in_if.cmd),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_filt  (out_if.filtered_rate),
  .out_raw   (out_if.raw_rate),
  .out_zero  (out_if.zero_interval)
);

/* test/bandwidth_meter_lowpass_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for bandwidth_meter_lowpass: random packet bursts and ticks
// checked against a bit-exact rate predictor. Depends on bwm_pkg, bwm_in_if, bwm_out_if.
module bandwidth_meter_lowpass_tb;
  import bwm_pkg::*;

  localparam int          RUN_LIMIT    = 2_000_000;
  localparam int          TICK_SETTLE  = 250;
  localparam int          PHASE_ITEMS  = 250;
  localparam logic [31:0] US_PER_SEC   = 32'd1000000;

  typedef logic [127:0] wide_t;

  typedef struct packed {
    logic [RATE_BITS-1:0] filt;
    logic [RATE_BITS-1:0] raw;
    logic                 zero;
  } rate_res_t;

  // Tracks the meter's state and queues the result each tick should produce.
  class rate_tracker;
    logic [PERIOD_W-1:0]  period;
    logic [TOTAL_W-1:0]   bytes;
    logic [RATE_BITS-1:0] smooth;
    logic [RATE_BITS-1:0] prev_raw;
    rate_res_t            rate_due[$];
    int errors;
    int packets;
    int ticks;
    int zero_ticks;
    int raw_sats;
    int floored;

    function new();
      period     = PERIOD_RESET;
      bytes      = '0;
      smooth     = '0;
      prev_raw   = '0;
      errors     = 0;
      packets    = 0;
      ticks      = 0;
      zero_ticks = 0;
      raw_sats   = 0;
      floored    = 0;
    endfunction

    function void set_period(logic [PERIOD_W-1:0] p);
      period = p;
    endfunction

    function logic [RATE_BITS-1:0] clip_rate(wide_t v);
      return (v > wide_t'(RATE_MAX)) ? RATE_MAX : v[RATE_BITS-1:0];
    endfunction

    function void take_item(logic cmd, logic [LEN_W-1:0] len, logic [ELAPSED_W-1:0] el);
      logic [TOTAL_W:0]     sum;
      wide_t                q;
      wide_t                two_t;
      wide_t                d;
      wide_t                pos;
      wide_t                neg;
      logic [RATE_BITS-1:0] raw;
      logic [RATE_BITS-1:0] filt;
      rate_res_t            r;
      if (cmd == CMD_PACKET) begin
        packets++;
        sum   = {1'b0, bytes} + (TOTAL_W + 1)'(len);
        bytes = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];
        return;
      end
      ticks++;
      if (el == '0) begin
        // flagged, nothing else moves
        zero_ticks++;
        r.filt = '0;
        r.raw  = '0;
        r.zero = 1'b1;
        rate_due.push_back(r);
        return;
      end
      d   = wide_t'(el);
      q   = wide_t'(bytes) * wide_t'(US_PER_SEC) / d;
      raw = clip_rate(q);
      if (q > wide_t'(RATE_MAX)) raw_sats++;
      two_t = wide_t'(period) << 1;
      pos   = wide_t'(raw) * d + wide_t'(prev_raw) * d;
      neg   = '0;
      if (two_t >= d) begin
        pos = pos + wide_t'(smooth) * (two_t - d);
      end else begin
        neg = wide_t'(smooth) * (d - two_t);
      end
      if (pos < neg) begin
        filt = '0;
        floored++;
      end else begin
        filt = clip_rate((pos - neg) / (two_t + d));
      end
      smooth   = filt;
      prev_raw = raw;
      bytes    = '0;
      r.filt   = filt;
      r.raw    = raw;
      r.zero   = 1'b0;
      rate_due.push_back(r);
    endfunction

    function void check_rate(logic [RATE_BITS-1:0] filt, logic [RATE_BITS-1:0] raw,
                             logic zero);
      rate_res_t e;
      if (rate_due.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: filt %0d raw %0d zero %0b",
                 $time, filt, raw, zero);
        return;
      end
      e = rate_due.pop_front();
      if (filt !== e.filt) begin
        errors++;
        $display("%0t: filtered_rate expected %0d actual %0d", $time, e.filt, filt);
      end
      if (raw !== e.raw) begin
        errors++;
        $display("%0t: raw_rate expected %0d actual %0d", $time, e.raw, raw);
      end
      if (zero !== e.zero) begin
        errors++;
        $display("%0t: zero_interval expected %0b actual %0b", $time, e.zero, zero);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [PERIOD_W-1:0] cfg_data;
  logic                steady;
  int                  cycle_count;
  int                  items_sent;
  int                  periods_used;

  bwm_in_if  in_ch ();
  bwm_out_if out_ch ();

  rate_tracker tracker = new();

  bandwidth_meter_lowpass dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, tracker.rate_due.size());
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random back-pressure, checked at the rising edge
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= steady || ($urandom_range(99) >= 30);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      tracker.check_rate(out_ch.filtered_rate, out_ch.raw_rate, out_ch.zero_interval);
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(logic cmd, logic [LEN_W-1:0] len, logic [ELAPSED_W-1:0] el);
    if (!steady) begin
      while ($urandom_range(99) < 30) begin
        in_ch.valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_ch.valid         <= 1'b1;
    in_ch.cmd           <= cmd;
    in_ch.packet_length <= len;
    in_ch.elapsed_us    <= el;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    tracker.take_item(cmd, len, el);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_packet(logic [LEN_W-1:0] len);
    send_item(CMD_PACKET, len, ELAPSED_W'($urandom));
  endtask

  task automatic send_tick(logic [ELAPSED_W-1:0] el);
    send_item(CMD_TICK, LEN_W'($urandom), el);
  endtask

  // Drain every outstanding tick, then let the engine go quiet.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (tracker.rate_due.size() != 0) @(posedge clk);
    repeat (TICK_SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_period(logic [PERIOD_W-1:0] p);
    cfg_we   <= 1'b1;
    cfg_data <= p;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.set_period(p);
    periods_used++;
  endtask

  function automatic logic [LEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 50) return LEN_W'($urandom);
    if (r < 70) return {LEN_W{1'b1}};
    if (r < 85) return LEN_W'($urandom_range(64));
    return LEN_W'($urandom_range(1500));
  endfunction

  function automatic logic [ELAPSED_W-1:0] pick_elapsed();
    int r;
    r = $urandom_range(99);
    if (r < 8)  return '0;
    if (r < 30) return ELAPSED_W'($urandom_range(16, 1));
    if (r < 55) return ELAPSED_W'($urandom_range(5000, 17));
    if (r < 78) return ELAPSED_W'($urandom_range(2_100_000, 5001));
    return ELAPSED_W'($urandom);
  endfunction

  // Burst of packets closed by a tick; the long bursts of big packets push the
  // raw rate into saturation when the interval is short.
  task automatic send_burst();
    int n;
    if ($urandom_range(99) < 85) n = $urandom_range(12);
    else n = $urandom_range(22, 15);
    repeat (n) send_packet(pick_length());
    send_tick(pick_elapsed());
  endtask

  initial begin
    logic [PERIOD_W-1:0] phase_period[5];
    int                  start_count;
    rst_n               = 1'b0;
    steady              = 1'b0;
    cfg_we              = 1'b0;
    cfg_data            = '0;
    in_ch.valid         = 1'b0;
    in_ch.cmd           = CMD_PACKET;
    in_ch.packet_length = '0;
    in_ch.elapsed_us    = '0;
    items_sent          = 0;
    periods_used        = 1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, at the reset period
    send_tick('0);
    send_packet('0);
    send_packet({LEN_W{1'b1}});
    send_tick(ELAPSED_W'(1000));
    send_tick(ELAPSED_W'(1000));
    // no bytes in either interval and d above 2T: numerator goes negative
    send_tick({ELAPSED_W{1'b1}});
    repeat (8) send_packet({LEN_W{1'b1}});
    send_tick('0);  // must not clear the byte count
    repeat (9) send_packet({LEN_W{1'b1}});
    send_tick(ELAPSED_W'(1));
    settle();

    phase_period[0] = PERIOD_W'(1000);
    phase_period[1] = {PERIOD_W{1'b1}};
    phase_period[2] = '0;
    phase_period[3] = PERIOD_W'(1000000);
    phase_period[4] = PERIOD_W'($urandom);
    for (int ph = 0; ph < 5; ph++) begin
      write_period(phase_period[ph]);
      steady      = (ph == 2);
      start_count = items_sent;
      while (items_sent - start_count < PHASE_ITEMS) send_burst();
      settle();
    end
    steady = 1'b0;

    $display("%0d packets and %0d ticks (%0d zero-interval) across %0d filter periods",
             tracker.packets, tracker.ticks, tracker.zero_ticks, periods_used);
    $display("%0d raw rates saturated, %0d filtered rates floored at zero",
             tracker.raw_sats, tracker.floored);
    if (tracker.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", tracker.errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/bwm_pkg.sv
design/bwm_in_if.sv
design/bwm_out_if.sv
design/bwm_addsub.sv
design/bwm_engine.sv
design/bandwidth_meter_lowpass.sv
design/bwm_checker.sv
test/bandwidth_meter_lowpass_tb.sv
